@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion name failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion name failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion name failed");

`endif

@@ sv/msps_pkg.sv @@
package msps_pkg;

    localparam int ROW_W      = 3;
    localparam int VAL_W      = 24;
    localparam int WEIGHT_W   = 16;
    localparam int CNT_W      = 4;
    localparam int COST_W     = 64;
    localparam int PAT_OUT_W  = 7;
    localparam int IDX_W      = 4;
    localparam int PIDX_W     = 8;
    localparam int MUL_W      = 25;
    localparam int PROD_W     = 50;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CNT_W-1:0]    STATE_COUNT_RST = 4'd8;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST      = 16'd4096;

    localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
    localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STATE_COUNT  = 2'd0,
        REG_FIRST_WEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mac_stat_t;

    typedef struct packed {
        logic                        valid;
        logic [PAT_OUT_W-1:0]        pattern;
        logic signed [COST_W-1:0]    change;
    } srch_res_t;

    function automatic logic signed [COST_W-1:0] sat_add(
        input logic signed [COST_W-1:0] a,
        input logic signed [COST_W-1:0] b
    );
        logic signed [COST_W-1:0] s;
        s = a + b;
        if ((a[COST_W-1] == b[COST_W-1]) && (s[COST_W-1] != a[COST_W-1]))
        begin
            s = a[COST_W-1] ? COST_MIN : COST_MAX;
        end
        return s;
    endfunction

    // Pairs are stored column by column: pair (i,j) with i < j sits at j*(j-1)/2 + i.
    function automatic logic [PIDX_W-1:0] pair_index(
        input logic [IDX_W-1:0] i,
        input logic [IDX_W-1:0] j
    );
        logic [PIDX_W-1:0] jj;
        logic [PIDX_W-1:0] prod;
        jj   = PIDX_W'(j);
        prod = jj * (jj - PIDX_W'(1));
        return (prod >> 1) + PIDX_W'(i);
    endfunction

endpackage

@@ sv/msps_cost_mem.sv @@
module msps_cost_mem #(
    parameter int DEPTH = 28,
    parameter int AW    = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                clear,
    input  logic                                we,
    input  logic [AW-1:0]                       waddr,
    input  logic signed [msps_pkg::COST_W-1:0]  wdata,
    input  logic [AW-1:0]                       raddr,
    output logic signed [msps_pkg::COST_W-1:0]  rdata
);

    logic signed [msps_pkg::COST_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]                   vld_reg;
    logic signed [msps_pkg::COST_W-1:0] rd_reg;
    logic                               rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    // An entry that was never written since the last clear reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                vld_reg <= '0;
            end
            else if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[raddr];
        end
    end

    assign rdata = rd_vld_reg ? rd_reg : '0;

endmodule

@@ sv/msps_mac.sv @@
module msps_mac #(
    parameter int AW = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [msps_pkg::VAL_W-1:0]    first_value,
    input  logic signed [msps_pkg::VAL_W-1:0]    first_ref,
    input  logic signed [msps_pkg::VAL_W-1:0]    second_value,
    input  logic signed [msps_pkg::VAL_W-1:0]    second_ref,
    input  logic [msps_pkg::WEIGHT_W-1:0]        weight,
    input  logic [AW-1:0]                        addr_in,
    input  logic signed [msps_pkg::COST_W-1:0]   rd_data,
    output logic [AW-1:0]                        addr,
    output logic                                 we,
    output logic signed [msps_pkg::COST_W-1:0]   wdata,
    output msps_pkg::mac_stat_t                  stat
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_P1,
        M_P2,
        M_LO,
        M_HI,
        M_COMB,
        M_ADD,
        M_WR
    } mac_state_t;

    mac_state_t state_reg;
    mac_state_t state_next;

    logic signed [msps_pkg::VAL_W-1:0]    m1_reg;
    logic signed [msps_pkg::VAL_W-1:0]    r1_reg;
    logic signed [msps_pkg::VAL_W-1:0]    m2_reg;
    logic signed [msps_pkg::VAL_W-1:0]    r2_reg;
    logic [msps_pkg::WEIGHT_W-1:0]        w_reg;
    logic [AW-1:0]                        addr_reg;
    logic signed [2*msps_pkg::VAL_W-1:0]  p1_reg;
    logic signed [2*msps_pkg::VAL_W-1:0]  p2_reg;
    logic [msps_pkg::VAL_W+msps_pkg::WEIGHT_W-1:0]   lo_reg;
    logic signed [msps_pkg::VAL_W+msps_pkg::WEIGHT_W:0] hi_reg;
    logic signed [msps_pkg::COST_W-1:0]   full_reg;
    logic signed [msps_pkg::COST_W-1:0]   c_reg;

    logic signed [msps_pkg::MUL_W-1:0]    mul_a;
    logic signed [msps_pkg::MUL_W-1:0]    mul_b;
    logic signed [msps_pkg::PROD_W-1:0]   prod;

    // One multiplier serves all four products. The weighted product m1*r1*w is
    // formed as two halves of m1*r1, each times the weight.
    always_comb
    begin
        case (state_reg)
            M_P1:
            begin
                mul_a = {m1_reg[msps_pkg::VAL_W-1], m1_reg};
                mul_b = {r1_reg[msps_pkg::VAL_W-1], r1_reg};
            end
            M_P2:
            begin
                mul_a = {m2_reg[msps_pkg::VAL_W-1], m2_reg};
                mul_b = {r2_reg[msps_pkg::VAL_W-1], r2_reg};
            end
            M_LO:
            begin
                mul_a = {1'b0, p1_reg[msps_pkg::VAL_W-1:0]};
                mul_b = {9'b0, w_reg};
            end
            M_HI:
            begin
                mul_a = {p1_reg[2*msps_pkg::VAL_W-1], p1_reg[2*msps_pkg::VAL_W-1:msps_pkg::VAL_W]};
                mul_b = {9'b0, w_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next = M_P1;
                end
            end
            M_P1:    state_next = M_P2;
            M_P2:    state_next = M_LO;
            M_LO:    state_next = M_HI;
            M_HI:    state_next = M_COMB;
            M_COMB:  state_next = M_ADD;
            M_ADD:   state_next = M_WR;
            M_WR:    state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            m1_reg   <= first_value;
            r1_reg   <= first_ref;
            m2_reg   <= second_value;
            r2_reg   <= second_ref;
            w_reg    <= weight;
            addr_reg <= addr_in;
        end
        case (state_reg)
            M_P1:   p1_reg <= prod[2*msps_pkg::VAL_W-1:0];
            M_P2:   p2_reg <= prod[2*msps_pkg::VAL_W-1:0];
            M_LO:   lo_reg <= prod[msps_pkg::VAL_W+msps_pkg::WEIGHT_W-1:0];
            M_HI:   hi_reg <= prod[msps_pkg::VAL_W+msps_pkg::WEIGHT_W:0];
            M_COMB: full_reg <= (64'(hi_reg) <<< msps_pkg::VAL_W) + 64'(lo_reg);
            // Floor shift of the weighted term, add the second product, times four.
            M_ADD:  c_reg <= ((full_reg >>> 12) + 64'(p2_reg)) <<< 2;
            default:
            begin
            end
        endcase
    end

    assign addr      = addr_reg;
    assign we        = (state_reg == M_WR);
    assign wdata     = msps_pkg::sat_add(rd_data, c_reg);
    assign stat.busy = (state_reg != M_IDLE);
    assign stat.done = (state_reg == M_WR);

endmodule

@@ sv/msps_search.sv @@
module msps_search #(
    parameter int MAX_STATES = 8,
    parameter int AW         = 5
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [$clog2(MAX_STATES+1)-1:0]            n_eff,
    input  logic signed [msps_pkg::COST_W-1:0]         rd_data,
    input  logic                                       res_ready,
    output logic [AW-1:0]                              addr,
    output logic                                       busy,
    output msps_pkg::srch_res_t                        res
);

    localparam int SW = $clog2(MAX_STATES);
    localparam int PW = MAX_STATES - 1;
    localparam int NW = $clog2(MAX_STATES + 1);
    localparam int IW = msps_pkg::IDX_W;
    localparam int OW = msps_pkg::PAT_OUT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } srch_state_t;

    srch_state_t state_reg;
    srch_state_t state_next;

    logic [PW-1:0]                       p_reg;
    logic [SW-1:0]                       a_reg;
    logic [SW-1:0]                       b_reg;
    logic signed [msps_pkg::COST_W-1:0]  acc_reg;
    logic signed [msps_pkg::COST_W-1:0]  best_reg;
    logic [PW-1:0]                       bestp_reg;
    logic                                d_vld_reg;
    logic                                d_diff_reg;
    logic                                d_lastp_reg;
    logic [PW-1:0]                       d_pat_reg;

    logic [SW-1:0]                       nm1;
    logic [SW-1:0]                       nm2;
    logic [PW-1:0]                       pat_mask;
    logic                                last_pat;
    logic                                last_b;
    logic                                last_pair;
    logic [PW-1:0]                       p_sh_a;
    logic [PW-1:0]                       p_sh_b;
    logic                                differ;
    logic signed [msps_pkg::COST_W-1:0]  sum;
    logic [PW+OW-1:0]                    pat_ext;

    assign nm1      = SW'(n_eff - NW'(1));
    assign nm2      = SW'(n_eff - NW'(2));
    assign pat_mask = ~({PW{1'b1}} << nm1);
    assign last_pat = (p_reg == pat_mask);
    assign last_b   = (b_reg == nm1);
    assign last_pair = last_b && (a_reg == nm2);
    assign p_sh_a   = p_reg >> a_reg;
    assign p_sh_b   = p_reg >> b_reg;
    // The last state never flips, so its sign bit reads as zero.
    assign differ   = p_sh_a[0] ^ (last_b ? 1'b0 : p_sh_b[0]);
    assign addr     = AW'(msps_pkg::pair_index(IW'(a_reg), IW'(b_reg)));
    assign sum      = msps_pkg::sat_add(acc_reg, d_diff_reg ? rd_data : '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (last_pair && last_pat)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = S_DONE;
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            d_vld_reg <= 1'b0;
            p_reg     <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            d_vld_reg <= (state_reg == S_RUN);
            if (start)
            begin
                p_reg <= PW'(1);
                a_reg <= '0;
                b_reg <= SW'(1);
            end
            else if (state_reg == S_RUN)
            begin
                if (last_pair)
                begin
                    p_reg <= p_reg + PW'(1);
                    a_reg <= '0;
                    b_reg <= SW'(1);
                end
                else if (last_b)
                begin
                    a_reg <= a_reg + SW'(1);
                    b_reg <= a_reg + SW'(2);
                end
                else
                begin
                    b_reg <= b_reg + SW'(1);
                end
            end
        end
    end

    // Memory data for a pair arrives in the cycle after its address, alongside these tags.
    always_ff @(posedge clk)
    begin
        d_diff_reg  <= differ;
        d_lastp_reg <= last_pair;
        d_pat_reg   <= p_reg;
        if (start)
        begin
            acc_reg   <= '0;
            best_reg  <= '0;
            bestp_reg <= '0;
        end
        else if (d_vld_reg)
        begin
            if (d_lastp_reg)
            begin
                acc_reg <= '0;
                if (sum < best_reg)
                begin
                    best_reg  <= sum;
                    bestp_reg <= d_pat_reg;
                end
            end
            else
            begin
                acc_reg <= sum;
            end
        end
    end

    assign pat_ext     = {{OW{1'b0}}, bestp_reg};
    assign busy        = (state_reg != S_IDLE);
    assign res.valid   = (state_reg == S_DONE);
    assign res.pattern = pat_ext[OW-1:0];
    assign res.change  = best_reg;

endmodule

@@ sv/matrix_sign_phase_search_core.sv @@
// Sign-phase search over the off-diagonal pair costs of one or two symmetric matrices.
// Input stream (s_axis): one transaction per upper off-diagonal element, with tlast on
// the final element of the set. A valid element runs through a shared multiplier, and
// the next element is taken once its pair cost has been written back; an element with bad
// indices is dropped and does not hold the input unless it carries tlast. After tlast the
// block walks every nonzero sign pattern, reading one stored pair cost per cycle from the
// single memory read port. Once the search result moves into the output register,
// m_axis_tvalid is high and elements of the next set are taken from that cycle on.
// Output stream (m_axis): one transaction per set, carrying the best pattern, its cost
// change and a changed flag in tuser. The result sits in an output register; a stalled
// receiver only holds the search in its final step, while elements of the next set can
// already be taken once the search result has moved into that register.
// Configuration (cfg_*): state count and first-matrix weight, which the user must write
// only while idle; the block itself does not enforce this. cfg_ready is always high.
// Reset clears all control state, restores the register defaults, and marks every pair
// cost as zero at once; the same happens to the pair costs after each result.
`include "assert_macros.svh"

module matrix_sign_phase_search_core #(
    parameter int MAX_STATES = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // row[2:0], col[5:3], first_value[29:6], first_ref[53:30],
    // second_value[77:54], second_ref[101:78], zero fill [103:102]
    input  logic [msps_pkg::IN_DATA_W-1:0]         s_axis_tdata,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // sign_pattern[6:0], best_change[70:7], zero fill [71]
    output logic [msps_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // changed[0]
    output logic [0:0]                             m_axis_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [msps_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [msps_pkg::WEIGHT_W-1:0]          cfg_data
);

    localparam int NP = MAX_STATES * (MAX_STATES - 1) / 2;
    localparam int AW = (NP > 1) ? $clog2(NP) : 1;
    localparam int NW = $clog2(MAX_STATES + 1);
    localparam int IW = msps_pkg::IDX_W;
    localparam int VW = msps_pkg::VAL_W;
    localparam int OW = msps_pkg::PAT_OUT_W;

    typedef enum logic [1:0] {
        T_IDLE,
        T_LOAD,
        T_SEARCH
    } top_state_t;

    top_state_t state_reg;
    top_state_t state_next;

    logic [msps_pkg::CNT_W-1:0]          state_count_reg;
    logic [msps_pkg::WEIGHT_W-1:0]       weight_reg;
    logic                                last_reg;
    logic                                out_valid_reg;
    logic [OW-1:0]                       out_pat_reg;
    logic signed [msps_pkg::COST_W-1:0]  out_change_reg;
    logic                                out_changed_reg;

    logic [NW-1:0]                       n_eff;
    logic [msps_pkg::ROW_W-1:0]          row;
    logic [msps_pkg::ROW_W-1:0]          col;
    logic signed [VW-1:0]                first_value;
    logic signed [VW-1:0]                first_ref;
    logic signed [VW-1:0]                second_value;
    logic signed [VW-1:0]                second_ref;
    logic                                in_fire;
    logic                                idx_ok;
    logic                                mac_start;
    logic                                srch_start;
    logic                                res_ready;
    logic                                out_load;

    msps_pkg::mac_stat_t                 mac_stat;
    msps_pkg::srch_res_t                 srch_res;
    logic                                srch_busy;
    logic [AW-1:0]                       mac_addr;
    logic [AW-1:0]                       srch_addr;
    logic [AW-1:0]                       mem_raddr;
    logic                                mem_we;
    logic signed [msps_pkg::COST_W-1:0]  mem_wdata;
    logic signed [msps_pkg::COST_W-1:0]  mem_rdata;

    assign row          = s_axis_tdata[2:0];
    assign col          = s_axis_tdata[5:3];
    assign first_value  = s_axis_tdata[29:6];
    assign first_ref    = s_axis_tdata[53:30];
    assign second_value = s_axis_tdata[77:54];
    assign second_ref   = s_axis_tdata[101:78];

    always_comb
    begin
        if (state_count_reg < msps_pkg::CNT_W'(2))
        begin
            n_eff = NW'(2);
        end
        else if (int'(state_count_reg) > MAX_STATES)
        begin
            n_eff = NW'(MAX_STATES);
        end
        else
        begin
            n_eff = NW'(state_count_reg);
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_count_reg <= msps_pkg::STATE_COUNT_RST;
            weight_reg      <= msps_pkg::WEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                msps_pkg::REG_STATE_COUNT:  state_count_reg <= cfg_data[msps_pkg::CNT_W-1:0];
                msps_pkg::REG_FIRST_WEIGHT: weight_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == T_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign idx_ok        = (row < col) && (IW'(col) < IW'(n_eff));
    assign mac_start     = in_fire && idx_ok;
    assign srch_start    = (in_fire && !idx_ok && s_axis_tlast) ||
                           ((state_reg == T_LOAD) && mac_stat.done && last_reg);
    assign res_ready     = !out_valid_reg || m_axis_tready;
    assign out_load      = srch_res.valid && res_ready;
    assign mem_raddr     = (state_reg == T_SEARCH) ? srch_addr : mac_addr;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (in_fire)
                begin
                    if (idx_ok)
                    begin
                        state_next = T_LOAD;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = T_SEARCH;
                    end
                end
            end
            T_LOAD:
            begin
                if (mac_stat.done)
                begin
                    state_next = last_reg ? T_SEARCH : T_IDLE;
                end
            end
            T_SEARCH:
            begin
                if (out_load)
                begin
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                last_reg <= s_axis_tlast;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pat_reg     <= srch_res.pattern;
            out_change_reg  <= srch_res.change;
            out_changed_reg <= srch_res.change[msps_pkg::COST_W-1];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_change_reg, out_pat_reg};
    assign m_axis_tuser  = out_changed_reg;

    msps_mac #(
        .AW (AW)
    ) u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mac_start),
        .first_value  (first_value),
        .first_ref    (first_ref),
        .second_value (second_value),
        .second_ref   (second_ref),
        .weight       (weight_reg),
        .addr_in      (AW'(msps_pkg::pair_index(IW'(row), IW'(col)))),
        .rd_data      (mem_rdata),
        .addr         (mac_addr),
        .we           (mem_we),
        .wdata        (mem_wdata),
        .stat         (mac_stat)
    );

    msps_cost_mem #(
        .DEPTH (NP),
        .AW    (AW)
    ) u_cost_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (out_load),
        .we    (mem_we),
        .waddr (mac_addr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    msps_search #(
        .MAX_STATES (MAX_STATES),
        .AW         (AW)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (srch_start),
        .n_eff     (n_eff),
        .rd_data   (mem_rdata),
        .res_ready (res_ready),
        .addr      (srch_addr),
        .busy      (srch_busy),
        .res       (srch_res)
    );

    `ASSERT_ALWAYS(a_no_accept_busy, !(s_axis_tready && (mac_stat.busy || srch_busy)))
    `ASSERT_IMPLIES(a_we_in_load, mem_we, state_reg == T_LOAD)
    `ASSERT_IMPLIES(a_change_nonpos, m_axis_tvalid, out_change_reg <= 0)
    `ASSERT_IMPLIES(a_nochange_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0)

endmodule

@@ tb/sv/matrix_sign_phase_search_core_test.sv @@
`timescale 1ns / 100ps

module matrix_sign_phase_search_core_test;

    import msps_pkg::*;

    localparam int STATE_LIMIT = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam logic [VAL_W-1:0] VAL_MOST_NEG = 24'h800000;
    localparam logic [VAL_W-1:0] VAL_MOST_POS = 24'h7FFFFF;

    typedef struct packed {
        logic             last;
        logic [VAL_W-1:0] second_ref;
        logic [VAL_W-1:0] second_value;
        logic [VAL_W-1:0] first_ref;
        logic [VAL_W-1:0] first_value;
        logic [ROW_W-1:0] col;
        logic [ROW_W-1:0] row;
    } element_t;

    typedef struct packed {
        logic [PAT_OUT_W-1:0]     pattern;
        logic                     changed;
        logic signed [COST_W-1:0] change;
    } search_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [WEIGHT_W-1:0]    cfg_data = '0;

    // Mirror of the block's registers and pair cost store.
    logic [CNT_W-1:0]       state_count_q = STATE_COUNT_RST;
    logic [WEIGHT_W-1:0]    weight_q = WEIGHT_RST;
    longint                 pair_cost [STATE_LIMIT][STATE_LIMIT];

    search_result_t         predicted_patterns [$];
    int                     mismatch_count = 0;
    int                     loaded_elements = 0;
    bit                     source_gaps_on = 1'b1;
    bit                     sink_gaps_on = 1'b1;
    int                     hold_off_request = 0;

    matrix_sign_phase_search_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int effective_states();
        if (state_count_q < 2)
        begin
            return 2;
        end
        if (state_count_q > STATE_LIMIT)
        begin
            return STATE_LIMIT;
        end
        return int'(state_count_q);
    endfunction

    // Sums in 65 bits and clamps when the top two bits disagree.
    function automatic longint add_saturated(input longint a, input longint b);
        logic [COST_W:0] wide;
        wide = {a[COST_W-1], a} + {b[COST_W-1], b};
        if (wide[COST_W] != wide[COST_W-1])
        begin
            return wide[COST_W] ? COST_MIN : COST_MAX;
        end
        return wide[COST_W-1:0];
    endfunction

    function automatic search_result_t search_best_pattern(input int n);
        search_result_t res;
        longint         best;
        longint         change;
        int             best_p;
        int             p;
        int             a;
        int             b;
        bit             sa;
        bit             sb;
        best = 0;
        best_p = 0;
        for (p = 1; p < (1 << (n - 1)); p++)
        begin
            change = 0;
            for (a = 0; a < n; a++)
            begin
                for (b = a + 1; b < n; b++)
                begin
                    sa = p[a];
                    // The last state never flips.
                    sb = (b < n - 1) ? p[b] : 1'b0;
                    if (sa != sb)
                    begin
                        change = add_saturated(change, pair_cost[a][b]);
                    end
                end
            end
            if (change < best)
            begin
                best = change;
                best_p = p;
            end
        end
        res.pattern = best_p[PAT_OUT_W-1:0];
        res.changed = (best < 0);
        res.change = best;
        return res;
    endfunction

    function automatic void accumulate_element(input element_t e);
        int     n;
        longint m1;
        longint r1;
        longint m2;
        longint r2;
        longint scaled;
        longint cost;
        n = effective_states();
        if (e.row < e.col && int'(e.col) < n)
        begin
            m1 = longint'($signed(e.first_value));
            r1 = longint'($signed(e.first_ref));
            m2 = longint'($signed(e.second_value));
            r2 = longint'($signed(e.second_ref));
            scaled = (m1 * r1 * longint'(weight_q)) >>> 12;
            cost = (scaled + m2 * r2) * 4;
            pair_cost[e.row][e.col] = add_saturated(pair_cost[e.row][e.col], cost);
            loaded_elements++;
        end
        if (e.last)
        begin
            predicted_patterns.push_back(search_best_pattern(n));
            foreach (pair_cost[i, j])
            begin
                pair_cost[i][j] = 0;
            end
        end
    endfunction

    function automatic element_t make_element(
        input int               row,
        input int               col,
        input logic [VAL_W-1:0] v1,
        input logic [VAL_W-1:0] r1,
        input logic [VAL_W-1:0] v2,
        input logic [VAL_W-1:0] r2,
        input logic             last
    );
        element_t e;
        e.row = ROW_W'(row);
        e.col = ROW_W'(col);
        e.first_value = v1;
        e.first_ref = r1;
        e.second_value = v2;
        e.second_ref = r2;
        e.last = last;
        return e;
    endfunction

    function automatic logic [VAL_W-1:0] rand_component();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 9))
            0: return VAL_MOST_NEG;
            1: return VAL_MOST_POS;
            2: return '0;
            3: return VAL_W'($signed(raw[4:0]));
            default: return raw[VAL_W-1:0];
        endcase
    endfunction

    function automatic element_t random_element(input int row, input int col, input bit single);
        return make_element(row, col, rand_component(), rand_component(),
                            single ? '0 : rand_component(), single ? '0 : rand_component(),
                            1'b0);
    endfunction

    task automatic send_element(input element_t e);
        if (source_gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, e.second_ref, e.second_value, e.first_ref, e.first_value,
                         e.col, e.row};
        s_axis_tlast <= e.last;
        do @(posedge clk); while (!s_axis_tready);
        accumulate_element(e);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (predicted_patterns.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Writes both registers and optionally the two unused indexes, keeping
    // cfg_valid high across back-to-back transactions.
    task automatic apply_config(
        input logic [WEIGHT_W-1:0] count_word,
        input logic [WEIGHT_W-1:0] weight_word,
        input bit                  poke_unused
    );
        logic [CFG_IDX_W-1:0] idx [4];
        logic [WEIGHT_W-1:0]  val [4];
        int                   total;
        int                   k;
        idx[0] = REG_STATE_COUNT;
        val[0] = count_word;
        idx[1] = REG_FIRST_WEIGHT;
        val[1] = weight_word;
        idx[2] = REG_SPARE_2;
        val[2] = WEIGHT_W'($urandom());
        idx[3] = REG_SPARE_3;
        val[3] = WEIGHT_W'($urandom());
        total = poke_unused ? 4 : 2;
        for (k = 0; k < total; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= val[k];
            do @(posedge clk); while (!cfg_ready);
            if (idx[k] == REG_STATE_COUNT)
            begin
                state_count_q = val[k][CNT_W-1:0];
            end
            else if (idx[k] == REG_FIRST_WEIGHT)
            begin
                weight_q = val[k];
            end
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_matrix_set(input bit single);
        element_t items [$];
        element_t swap;
        int       n;
        int       i;
        int       k;
        int       pick;
        n = effective_states();
        for (i = 0; i < n - 1; i++)
        begin
            for (k = i + 1; k < n; k++)
            begin
                items.push_back(random_element(i, k, single));
            end
        end
        repeat ($urandom_range(0, 2))
        begin
            i = $urandom_range(0, n - 2);
            items.push_back(random_element(i, $urandom_range(i + 1, n - 1), single));
        end
        for (k = items.size() - 1; k > 0; k--)
        begin
            pick = $urandom_range(0, k);
            swap = items[k];
            items[k] = items[pick];
            items[pick] = swap;
        end
        // Occasionally slip in an element that is below the diagonal or on it.
        if ($urandom_range(0, 4) == 0)
        begin
            i = $urandom_range(0, 7);
            items.insert($urandom_range(0, items.size() - 1),
                         random_element(i, $urandom_range(0, i), single));
        end
        items[items.size() - 1].last = 1'b1;
        for (k = 0; k < items.size(); k++)
        begin
            send_element(items[k]);
        end
    endtask

    task automatic send_noise_set();
        element_t e;
        int       len;
        int       k;
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++)
        begin
            e = random_element($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 1));
            e.last = (k == len - 1);
            send_element(e);
        end
    endtask

    task automatic test_directed_cases();
        // Defaults: eight states, unit weight. A set that lowers nothing.
        send_element(make_element(0, 1, '0, '0, '0, '0, 1'b1));
        // Extremes plus bad indices, with the last flag on a bad element.
        send_element(make_element(0, 7, VAL_MOST_NEG, VAL_MOST_POS, VAL_MOST_POS,
                                  VAL_MOST_NEG, 1'b0));
        send_element(make_element(3, 3, VAL_MOST_NEG, VAL_MOST_NEG, VAL_MOST_NEG,
                                  VAL_MOST_NEG, 1'b0));
        send_element(make_element(7, 1, VAL_MOST_NEG, VAL_MOST_POS, '0, '0, 1'b0));
        send_element(make_element(0, 0, VAL_MOST_POS, VAL_MOST_NEG, '0, '0, 1'b0));
        send_element(make_element(6, 7, VAL_MOST_POS, VAL_MOST_POS, VAL_MOST_POS,
                                  VAL_MOST_POS, 1'b0));
        send_element(make_element(5, 2, VAL_MOST_NEG, VAL_MOST_POS, '0, '0, 1'b1));
        drain_results();

        // Three states, full weight; columns at or above the state count are dropped.
        apply_config(16'hFFF3, 16'hFFFF, 1'b1);
        send_element(make_element(0, 1, VAL_MOST_NEG, VAL_MOST_POS, '0, '0, 1'b0));
        send_element(make_element(0, 2, 24'h000100, 24'h000100, '0, '0, 1'b0));
        send_element(make_element(2, 7, VAL_MOST_NEG, VAL_MOST_POS, '0, '0, 1'b0));
        send_element(make_element(0, 3, VAL_MOST_NEG, VAL_MOST_POS, '0, '0, 1'b0));
        send_element(make_element(1, 2, 24'hFFFFFF, 24'h123456, 24'h000001,
                                  24'hFFFFFF, 1'b1));
        // Two patterns reach the same change; the first one must win.
        send_element(make_element(0, 1, 24'hFFFFFF, 24'h000001, '0, '0, 1'b0));
        send_element(make_element(1, 2, '0, '0, '0, '0, 1'b1));
        drain_results();

        // A state count below the range clamps up, zero weight drops the first term.
        apply_config(16'h0000, 16'h0000, 1'b0);
        send_element(make_element(0, 1, VAL_MOST_POS, VAL_MOST_POS, 24'h000001,
                                  24'hFFFFFF, 1'b0));
        send_element(make_element(0, 2, VAL_MOST_NEG, VAL_MOST_POS, '0, '0, 1'b1));
        drain_results();

        // A state count above the range clamps down; flipping state 6 sets the top bit.
        apply_config(16'h000F, 16'h0001, 1'b0);
        send_element(make_element(6, 7, VAL_MOST_NEG, VAL_MOST_POS, '0, '0, 1'b0));
        send_element(make_element(1, 7, '0, '0, 24'h000040, 24'h000040, 1'b1));
        drain_results();

        apply_config(16'h0001, 16'h8001, 1'b0);
        send_element(make_element(0, 1, 24'hABCDEF, 24'h654321, 24'h00FF00,
                                  24'hFF00FF, 1'b1));
        drain_results();
    endtask

    task automatic test_random_sets(input int element_goal);
        logic [WEIGHT_W-1:0] weight_word;
        int                  goal_mark;
        int                  set_total;
        int                  s;
        goal_mark = loaded_elements + element_goal;
        while (loaded_elements < goal_mark)
        begin
            drain_results();
            case ($urandom_range(0, 5))
                0: weight_word = '0;
                1: weight_word = '1;
                2: weight_word = WEIGHT_RST;
                default: weight_word = WEIGHT_W'($urandom());
            endcase
            apply_config({12'($urandom()), 4'($urandom_range(0, 15))}, weight_word,
                         $urandom_range(0, 3) == 0);
            set_total = $urandom_range(1, 5);
            for (s = 0; s < set_total; s++)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    send_matrix_set($urandom_range(0, 2) == 0);
                end
                else
                begin
                    send_noise_set();
                end
            end
        end
        drain_results();
    endtask

    task automatic test_output_backpressure();
        int k;
        apply_config(16'd2, WEIGHT_W'($urandom()), 1'b0);
        source_gaps_on = 1'b0;
        hold_off_request = 400;
        // Short sets keep coming while the receiver is held off, so the result
        // register fills and the input side has to stall.
        for (k = 0; k < 10; k++)
        begin
            send_element(make_element(0, 1, rand_component(), rand_component(),
                                      rand_component(), rand_component(), 1'b1));
        end
        source_gaps_on = 1'b1;
        drain_results();
    endtask

    task automatic test_large_costs();
        int k;
        apply_config(16'd3, 16'hFFFF, 1'b0);
        // Maximal negative costs pile up on one pair and then on a second one,
        // so the stored sums and the pattern sums reach far beyond 32 bits.
        for (k = 0; k < 37; k++)
        begin
            send_element(make_element(0, 1, VAL_MOST_NEG, VAL_MOST_POS, VAL_MOST_POS,
                                      VAL_MOST_NEG, 1'b0));
        end
        for (k = 0; k < 3; k++)
        begin
            send_element(make_element(0, 2, VAL_MOST_NEG, VAL_MOST_POS, VAL_MOST_POS,
                                      VAL_MOST_NEG, k == 2));
        end
        drain_results();
    endtask

    task automatic test_streaming_without_gaps();
        source_gaps_on = 1'b0;
        sink_gaps_on = 1'b0;
        test_random_sets(150);
    endtask

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_request > 0)
            begin
                stall_left = hold_off_request;
                hold_off_request = 0;
            end
            else if (stall_left == 0 && sink_gaps_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin : result_checker
        search_result_t           want;
        logic [PAT_OUT_W-1:0]     got_pattern;
        logic signed [COST_W-1:0] got_change;
        logic                     got_changed;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got_pattern = m_axis_tdata[PAT_OUT_W-1:0];
                got_change = m_axis_tdata[PAT_OUT_W +: COST_W];
                got_changed = m_axis_tuser[0];
                if (predicted_patterns.size() == 0)
                begin
                    $error("result transaction with no search pending: pattern %0d", got_pattern);
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_patterns.pop_front();
                    if (got_pattern !== want.pattern)
                    begin
                        $error("sign_pattern: expected %0d, actual %0d", want.pattern,
                               got_pattern);
                        mismatch_count++;
                    end
                    if (got_changed !== want.changed)
                    begin
                        $error("changed: expected %0d, actual %0d", want.changed, got_changed);
                        mismatch_count++;
                    end
                    if (got_change !== want.change)
                    begin
                        $error("best_change: expected %0d, actual %0d", want.change,
                               got_change);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        #1_000_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_sets(1000);
        test_output_backpressure();
        test_large_costs();
        test_streaming_without_gaps();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && predicted_patterns.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
